// ===== rtl/opd_pkg.sv =====
// Shared types, sizes and float compare helpers for the dedup chain.
package opd_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned PosW       = 8;

  // Token handed from cell to cell, one per chain slot.
  typedef struct packed {
    logic              valid;   // slot holds a transaction
    logic              start;   // transaction opens a new sequence
    logic              placed;  // already stored in an upstream cell
    logic              dup;     // matched an upstream entry, no result
    logic [PosW-1:0]   pos;     // running index, wraps at 8 bits
    logic [ValueW-1:0] value;
  } token_t;

  function automatic logic is_nan(input logic [ValueW-1:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  // Float equality: +0 == -0, NaN matches nothing.
  function automatic logic float_eq(input logic [ValueW-1:0] a,
                                    input logic [ValueW-1:0] b);
    logic both_zero;
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (is_nan(a) || is_nan(b)) begin
      return 1'b0;
    end
    return both_zero || (a == b);
  endfunction

endpackage

// ===== rtl/opd_if.sv =====
// Handshake channel interfaces for dedup input and result streams.
interface opd_in_if;
  import opd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] sample_value;
  logic              start_req;

  modport source (output valid, output sample_value, output start_req, input ready);
  modport sink   (input valid, input sample_value, input start_req, output ready);
endinterface

interface opd_out_if;
  import opd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] kept_value;
  logic [PosW-1:0]   position;
  logic              overflow;

  modport source (output valid, output kept_value, output position, output overflow,
                  input ready);
  modport sink   (input valid, input kept_value, input position, input overflow,
                  output ready);
endinterface

// ===== rtl/order_preserving_dedup_core.sv =====
// Top level: order-preserving float dedup built as a systolic chain of cells.
// A result passes through the 256 cell token registers (the first loaded at accept) and then the output register.
// Throughput: one transaction per cycle while the result port is not stalled; the whole chain advances in lockstep.
// Back-pressure on the result port freezes every cell; input ready follows it.
// Reset (async, active low) empties all entries and drops every in-flight slot.
// No clearing pass: entry valid bits reset at once, so input is accepted as soon as reset is released.
module order_preserving_dedup_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  opd_in_if.sink     in_i,
  opd_out_if.source  out_o
);
  import opd_pkg::*;

  // Global advance: chain moves when the output register is free or drained.
  logic   en;
  token_t tok [TableDepth+1];

  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q;
  logic [PosW-1:0]   out_pos_q, out_pos_d;
  logic              out_ovf_q, out_ovf_d;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // Slot zero is the incoming transaction; a bubble enters when nothing is offered.
  assign tok[0] = token_t'{
    valid:  in_i.valid,
    start:  in_i.start_req,
    placed: 1'b0,
    dup:    1'b0,
    pos:    '0,
    value:  in_i.sample_value
  };

  // Each cell owns one table entry. Entries fill as a prefix, so the first
  // empty cell a fresh value meets is exactly slot seen_count. A start token
  // clears every cell it passes after claiming cell zero; later tokens trail
  // it and so see the cleared table, earlier ones are already downstream.
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    opd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  // Chain tail: duplicates vanish; unplaced non-duplicates overflowed.
  always_comb begin
    out_valid_d = tok[TableDepth].valid && !tok[TableDepth].dup;
    out_ovf_d   = !tok[TableDepth].placed;
    out_pos_d   = tok[TableDepth].placed ? tok[TableDepth].pos : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_value_q <= tok[TableDepth].value;
      out_pos_q   <= out_pos_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kept_value = out_value_q;
  assign out_o.position   = out_pos_q;
  assign out_o.overflow   = out_ovf_q;

endmodule

// ===== rtl/opd_cell.sv =====
// One table entry of the dedup chain plus its outgoing token register.
module opd_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  opd_pkg::token_t tok_i,
  output opd_pkg::token_t tok_o
);
  import opd_pkg::*;

  logic              entry_valid_q, entry_valid_d;
  logic [ValueW-1:0] entry_q, entry_d;
  token_t            tok_q, tok_d;
  logic              live, eff_valid, hit, store;

  always_comb begin
    live      = tok_i.valid && !tok_i.placed && !tok_i.dup;
    // a start token sees the table as already cleared
    eff_valid = entry_valid_q && !tok_i.start;
    hit       = live && eff_valid && float_eq(tok_i.value, entry_q);
    store     = live && !eff_valid;

    tok_d = tok_i;
    if (store) begin
      tok_d.placed = 1'b1;
    end
    if (hit) begin
      tok_d.dup = 1'b1;
    end
    if (live && eff_valid && !hit) begin
      tok_d.pos = tok_i.pos + PosW'(1);
    end

    entry_valid_d = entry_valid_q;
    entry_d       = entry_q;
    if (store) begin
      entry_valid_d = 1'b1;
      entry_d       = tok_i.value;
    end else if (tok_i.valid && tok_i.start) begin
      entry_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
      tok_q         <= '0;
    end else if (en_i) begin
      entry_valid_q <= entry_valid_d;
      tok_q         <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/opd_checker.sv =====
// Port-level checker for the dedup core, bound to the top level.
module opd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_value_i,
  input logic [7:0]  out_position_i,
  input logic        out_overflow_i
);

  // Input is refused exactly when a result is stalled.
  a_ready_tracks_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == !(out_valid_i && !out_ready_i))
    else $error("input ready disagrees with output stall");

  // Overflowed results carry position zero.
  a_ovf_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_overflow_i) |-> (out_position_i == 8'd0))
    else $error("overflow result with nonzero position");

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(out_value_i) && $stable(out_position_i) && $stable(out_overflow_i)))
    else $error("result changed while stalled");

endmodule

bind order_preserving_dedup_core opd_checker u_opd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_value_i    (out_o.kept_value),
  .out_position_i (out_o.position),
  .out_overflow_i (out_o.overflow)
);
